>>> src/ilac_pkg.sv
// Shared types and constants of the lattice agreement counter.
package ilac_pkg;

  // Field widths of the transaction ports
  localparam int SIDE_W = 7;
  localparam int IDX_W  = 12;
  localparam int TOT_W  = 14;
  localparam int EQ_W   = 13;
  localparam int SIM_W  = 16;
  localparam int CHG_W  = 6;
  localparam int STEP_W = 4;
  localparam int NBR_W  = 4;

  // Register map: paddr[2] selects the register word
  localparam logic REG_SIDE = 1'b0;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

  // Operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_COUNT = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Result kinds
  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Window walk: centre read first, then eight neighbours, then one drain step
  localparam logic [STEP_W-1:0] STEP_CENTER = 4'd0;
  localparam logic [STEP_W-1:0] STEP_LAST   = 4'd9;

  // One lattice site: spin and reference pixel
  typedef struct packed {
    logic spin;
    logic refpx;
  } cell_t;

endpackage

>>> src/ilac_store.sv
// Single-port-write, single-port-read site memory with registered read data.
module ilac_store #(
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  ilac_pkg::cell_t          wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output ilac_pkg::cell_t          rdata_o
);

  ilac_pkg::cell_t mem_q [DEPTH];
  ilac_pkg::cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ising_lattice_agreement_counter.sv
// Top level of the lattice agreement counter: register port, sequencer and walk.
//
// The block stores a square spin lattice and a reference image, column-major,
// and answers three kinds of input transaction on a valid/stall channel:
//   write - stores one spin and one reference pixel.
//   count - walks every site and returns the number of spins equal to the
//           reference and the summed count of agreeing 8-neighbours.
//   query - returns whether one spin equals its reference and
//           2*(neighbours - 2*agreeing neighbours) around it.
// Writes and queries outside the lattice in use, and operation 3, give no
// result. The side in use is set over the APB port (register 0, reset 64).
// Every site visit runs a window walk (centre, eight neighbours, drain step)
// through the single read port of the site memory; a query first finds
// col = index / side by repeated subtraction.
// The input stalls for the whole walk; one item is in work at a time.
// The result sits in an output register until taken; a stalled result holds,
// and a finished walk waits for that register to free before the next item.
// Reset clears the sequencer and the result register; the memories are not
// cleared and must be written before they are read.
module ising_lattice_agreement_counter #(
  parameter int MAX_SIDE = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        operation_i,
  input  logic [ilac_pkg::IDX_W-1:0]        pixel_index_i,
  input  logic                              spin_value_i,
  input  logic                              data_value_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              result_kind_o,
  output logic [ilac_pkg::EQ_W-1:0]         count_equal_data_o,
  output logic [ilac_pkg::SIM_W-1:0]        count_similar_o,
  output logic                              equal_to_data_o,
  output logic signed [ilac_pkg::CHG_W-1:0] similarity_change_o
);

  localparam int Depth    = MAX_SIDE * MAX_SIDE;
  localparam int AddrW    = $clog2(Depth);
  localparam int SideClip = (MAX_SIDE > 127) ? 127 : MAX_SIDE;
  localparam int SideW1   = ilac_pkg::SIDE_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WIN,
    ST_FIN
  } state_e;

  state_e                          state_q, state_d;
  logic [ilac_pkg::SIDE_W-1:0]     side_q, side_d;
  logic [ilac_pkg::STEP_W-1:0]     step_q, step_d;
  logic [ilac_pkg::SIDE_W-1:0]     col_q, col_d;
  logic [ilac_pkg::SIDE_W-1:0]     row_q, row_d;
  logic [ilac_pkg::IDX_W-1:0]      rem_q, rem_d;
  logic [AddrW-1:0]                addr_q, addr_d;
  logic                            kind_q, kind_d;
  logic                            rd_ctr_q, rd_ctr_d;
  logic                            rd_nb_q, rd_nb_d;
  logic                            centre_q, centre_d;
  logic                            eqd_q, eqd_d;
  logic [ilac_pkg::NBR_W-1:0]      agree_q, agree_d;
  logic [ilac_pkg::NBR_W-1:0]      neigh_q, neigh_d;
  logic [ilac_pkg::EQ_W-1:0]       eq_q, eq_d;
  logic [ilac_pkg::SIM_W-1:0]      sim_q, sim_d;
  logic                            out_valid_q, out_valid_d;
  logic                            out_kind_q, out_kind_d;
  logic [ilac_pkg::EQ_W-1:0]       out_eq_q, out_eq_d;
  logic [ilac_pkg::SIM_W-1:0]      out_sim_q, out_sim_d;
  logic                            out_eqd_q, out_eqd_d;
  logic [ilac_pkg::CHG_W-1:0]      out_chg_q, out_chg_d;

  logic [ilac_pkg::SIDE_W-1:0]     side_eff;
  logic [ilac_pkg::TOT_W-1:0]      total;
  logic                            idx_ok;
  logic                            in_accept;
  logic                            cfg_write;
  logic [SideW1-1:0]               col_inc;
  logic [SideW1-1:0]               row_inc;
  logic [SideW1-1:0]               side_ext;
  logic [2:0]                      nbr;
  logic                            cn, cp, rn, rp;
  logic                            nb_ok;
  logic [AddrW-1:0]                side_a;
  logic [AddrW-1:0]                off_col;
  logic [AddrW-1:0]                off_row;
  logic [AddrW-1:0]                nb_addr;
  logic [AddrW-1:0]                rd_addr;
  logic                            mem_we;
  ilac_pkg::cell_t                 mem_wdata;
  ilac_pkg::cell_t                 rd_cell;

  // Side in use: zero reads as one, clip to the largest supported side
  always_comb begin
    side_eff = side_q;
    if (side_q == '0) begin
      side_eff = ilac_pkg::SIDE_W'(1);
    end else if (side_q > ilac_pkg::SIDE_W'(SideClip)) begin
      side_eff = ilac_pkg::SIDE_W'(SideClip);
    end
  end

  assign total     = ilac_pkg::TOT_W'(side_eff) * ilac_pkg::TOT_W'(side_eff);
  assign idx_ok    = ilac_pkg::TOT_W'(pixel_index_i) < total;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept = in_valid_i && !in_stall_o;

  // APB: always ready, one register word
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == ilac_pkg::REG_SIDE);
  assign prdata    = (paddr[2] == ilac_pkg::REG_SIDE) ? 32'(side_q) : '0;

  assign col_inc  = SideW1'(col_q) + SideW1'(1);
  assign row_inc  = SideW1'(row_q) + SideW1'(1);
  assign side_ext = SideW1'(side_eff);

  // Neighbour offsets for walk steps one to eight
  assign nbr = 3'(step_q - ilac_pkg::STEP_W'(1));
  always_comb begin
    cn = 1'b0;
    cp = 1'b0;
    rn = 1'b0;
    rp = 1'b0;
    case (nbr)
      3'd0: begin cn = 1'b1; rn = 1'b1; end
      3'd1: begin cn = 1'b1; end
      3'd2: begin cn = 1'b1; rp = 1'b1; end
      3'd3: begin rn = 1'b1; end
      3'd4: begin rp = 1'b1; end
      3'd5: begin cp = 1'b1; rn = 1'b1; end
      3'd6: begin cp = 1'b1; end
      3'd7: begin cp = 1'b1; rp = 1'b1; end
      default: ;
    endcase
  end

  // Clip the window at the lattice border
  assign nb_ok = (!cn || (col_q != '0)) && (!cp || (col_inc < side_ext)) &&
                 (!rn || (row_q != '0)) && (!rp || (row_inc < side_ext));

  assign side_a  = AddrW'(side_eff);
  assign off_col = cn ? (AddrW'(0) - side_a) : (cp ? side_a : '0);
  assign off_row = rn ? {AddrW{1'b1}} : (rp ? AddrW'(1) : '0);
  assign nb_addr = addr_q + off_col + off_row;
  assign rd_addr = (step_q == ilac_pkg::STEP_CENTER) ? addr_q : nb_addr;

  assign mem_wdata = '{spin: spin_value_i, refpx: data_value_i};

  always_comb begin
    state_d     = state_q;
    side_d      = side_q;
    step_d      = step_q;
    col_d       = col_q;
    row_d       = row_q;
    rem_d       = rem_q;
    addr_d      = addr_q;
    kind_d      = kind_q;
    rd_ctr_d    = 1'b0;
    rd_nb_d     = 1'b0;
    centre_d    = centre_q;
    eqd_d       = eqd_q;
    agree_d     = agree_q;
    neigh_d     = neigh_q;
    eq_d        = eq_q;
    sim_d       = sim_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_kind_d  = out_kind_q;
    out_eq_d    = out_eq_q;
    out_sim_d   = out_sim_q;
    out_eqd_d   = out_eqd_q;
    out_chg_d   = out_chg_q;
    mem_we      = 1'b0;

    if (cfg_write) begin
      side_d = pwdata[ilac_pkg::SIDE_W-1:0];
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (operation_i)
            ilac_pkg::OP_WRITE: begin
              mem_we = idx_ok;
            end
            ilac_pkg::OP_COUNT: begin
              state_d = ST_WIN;
              step_d  = ilac_pkg::STEP_CENTER;
              col_d   = '0;
              row_d   = '0;
              addr_d  = '0;
              eq_d    = '0;
              sim_d   = '0;
              kind_d  = ilac_pkg::KIND_COUNT;
            end
            ilac_pkg::OP_QUERY: begin
              if (idx_ok) begin
                state_d = ST_DIV;
                step_d  = ilac_pkg::STEP_CENTER;
                rem_d   = pixel_index_i;
                col_d   = '0;
                addr_d  = AddrW'(pixel_index_i);
                kind_d  = ilac_pkg::KIND_QUERY;
              end
            end
            default: ;
          endcase
        end
      end

      // Split the index into column and row by repeated subtraction
      ST_DIV: begin
        if (rem_q >= ilac_pkg::IDX_W'(side_eff)) begin
          rem_d = rem_q - ilac_pkg::IDX_W'(side_eff);
          col_d = ilac_pkg::SIDE_W'(col_inc);
        end else begin
          row_d   = ilac_pkg::SIDE_W'(rem_q);
          state_d = ST_WIN;
        end
      end

      ST_WIN: begin
        step_d = step_q + ilac_pkg::STEP_W'(1);
        if (step_q == ilac_pkg::STEP_CENTER) begin
          agree_d  = '0;
          neigh_d  = '0;
          rd_ctr_d = 1'b1;
        end else if (step_q != ilac_pkg::STEP_LAST) begin
          if (nb_ok) begin
            rd_nb_d = 1'b1;
            neigh_d = neigh_q + ilac_pkg::NBR_W'(1);
          end
        end

        // Consume the read issued in the previous cycle
        if (rd_ctr_q) begin
          centre_d = rd_cell.spin;
          eqd_d    = (rd_cell.spin == rd_cell.refpx);
          if (kind_q == ilac_pkg::KIND_COUNT) begin
            eq_d = eq_q + ilac_pkg::EQ_W'(rd_cell.spin == rd_cell.refpx);
          end
        end
        if (rd_nb_q && (rd_cell.spin == centre_q)) begin
          agree_d = agree_q + ilac_pkg::NBR_W'(1);
          if (kind_q == ilac_pkg::KIND_COUNT) begin
            sim_d = sim_q + ilac_pkg::SIM_W'(1);
          end
        end

        if (step_q == ilac_pkg::STEP_LAST) begin
          if ((kind_q == ilac_pkg::KIND_QUERY) ||
              ((col_inc == side_ext) && (row_inc == side_ext))) begin
            state_d = ST_FIN;
          end else begin
            // Advance to the next site in column-major order
            step_d = ilac_pkg::STEP_CENTER;
            addr_d = addr_q + AddrW'(1);
            if (row_inc == side_ext) begin
              row_d = '0;
              col_d = ilac_pkg::SIDE_W'(col_inc);
            end else begin
              row_d = ilac_pkg::SIDE_W'(row_inc);
            end
          end
        end
      end

      // Hold the finished result until the output register frees
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_kind_d  = kind_q;
          if (kind_q == ilac_pkg::KIND_COUNT) begin
            out_eq_d  = eq_q;
            out_sim_d = sim_q;
            out_eqd_d = 1'b0;
            out_chg_d = '0;
          end else begin
            out_eq_d  = '0;
            out_sim_d = '0;
            out_eqd_d = eqd_q;
            out_chg_d = (ilac_pkg::CHG_W'(neigh_q) << 1) -
                        (ilac_pkg::CHG_W'(agree_q) << 2);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      side_q      <= ilac_pkg::SIDE_RESET;
      step_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      rem_q       <= '0;
      addr_q      <= '0;
      kind_q      <= ilac_pkg::KIND_COUNT;
      rd_ctr_q    <= 1'b0;
      rd_nb_q     <= 1'b0;
      centre_q    <= 1'b0;
      eqd_q       <= 1'b0;
      agree_q     <= '0;
      neigh_q     <= '0;
      eq_q        <= '0;
      sim_q       <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= ilac_pkg::KIND_COUNT;
      out_eq_q    <= '0;
      out_sim_q   <= '0;
      out_eqd_q   <= 1'b0;
      out_chg_q   <= '0;
    end else begin
      state_q     <= state_d;
      side_q      <= side_d;
      step_q      <= step_d;
      col_q       <= col_d;
      row_q       <= row_d;
      rem_q       <= rem_d;
      addr_q      <= addr_d;
      kind_q      <= kind_d;
      rd_ctr_q    <= rd_ctr_d;
      rd_nb_q     <= rd_nb_d;
      centre_q    <= centre_d;
      eqd_q       <= eqd_d;
      agree_q     <= agree_d;
      neigh_q     <= neigh_d;
      eq_q        <= eq_d;
      sim_q       <= sim_d;
      out_valid_q <= out_valid_d;
      out_kind_q  <= out_kind_d;
      out_eq_q    <= out_eq_d;
      out_sim_q   <= out_sim_d;
      out_eqd_q   <= out_eqd_d;
      out_chg_q   <= out_chg_d;
    end
  end

  ilac_store #(
    .DEPTH (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AddrW'(pixel_index_i)),
    .wdata_i (mem_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_cell)
  );

  assign out_valid_o         = out_valid_q;
  assign result_kind_o       = out_kind_q;
  assign count_equal_data_o  = out_eq_q;
  assign count_similar_o     = out_sim_q;
  assign equal_to_data_o     = out_eqd_q;
  assign similarity_change_o = $signed(out_chg_q);

endmodule

>>> tb/ising_lattice_agreement_counter_test.sv
// Self-checking testbench for the lattice agreement counter.
`timescale 1ns / 100ps

module ising_lattice_agreement_counter_test;

  localparam int LATTICE_MAX  = 64;
  localparam int SITE_COUNT   = LATTICE_MAX * LATTICE_MAX;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] SIDE_ADDR = {ilac_pkg::REG_SIDE, 2'b00};
  // an item that gives no result finishes in its accept cycle; settle a little anyway
  localparam int SETTLE_CYCLES = 100;
  localparam int END_CYCLES    = 200;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  typedef struct {
    logic                              kind;
    logic [ilac_pkg::EQ_W-1:0]         eq_count;
    logic [ilac_pkg::SIM_W-1:0]        sim_count;
    logic                              eq_data;
    logic signed [ilac_pkg::CHG_W-1:0] change;
  } lattice_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic                       in_valid_i    = 1'b0;
  logic                       in_stall_o;
  logic [1:0]                 operation_i   = ilac_pkg::OP_WRITE;
  logic [ilac_pkg::IDX_W-1:0] pixel_index_i = '0;
  logic                       spin_value_i  = 1'b0;
  logic                       data_value_i  = 1'b0;

  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic                              result_kind_o;
  logic [ilac_pkg::EQ_W-1:0]         count_equal_data_o;
  logic [ilac_pkg::SIM_W-1:0]        count_similar_o;
  logic                              equal_to_data_o;
  logic signed [ilac_pkg::CHG_W-1:0] similarity_change_o;

  // predictor state
  logic                        spin_mem  [SITE_COUNT];
  logic                        refpx_mem [SITE_COUNT];
  logic [ilac_pkg::SIDE_W-1:0] side_cfg = ilac_pkg::SIDE_RESET;
  lattice_result_t             pending_results[$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  bit          no_idle     = 1'b0;
  int unsigned stall_left  = 0;

  ising_lattice_agreement_counter dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .operation_i         (operation_i),
    .pixel_index_i       (pixel_index_i),
    .spin_value_i        (spin_value_i),
    .data_value_i        (data_value_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .result_kind_o       (result_kind_o),
    .count_equal_data_o  (count_equal_data_o),
    .count_similar_o     (count_similar_o),
    .equal_to_data_o     (equal_to_data_o),
    .similarity_change_o (similarity_change_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones, none at all in quiet stretches
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned side_in_use();
    if (side_cfg == 0) return 1;
    if (side_cfg > LATTICE_MAX) return LATTICE_MAX;
    return 32'(side_cfg);
  endfunction

  // Agreeing cells of the clipped 3x3 window, centre included; cells gets the window size.
  function automatic int unsigned window_agree(input int unsigned s, input int unsigned col,
                                               input int unsigned row,
                                               output int unsigned cells);
    int unsigned lo_c, hi_c, lo_r, hi_r, agree;
    logic centre;
    lo_c   = (col > 0) ? col - 1 : 0;
    hi_c   = (col + 1 < s) ? col + 1 : s - 1;
    lo_r   = (row > 0) ? row - 1 : 0;
    hi_r   = (row + 1 < s) ? row + 1 : s - 1;
    centre = spin_mem[col * s + row];
    agree  = 0;
    for (int unsigned c = lo_c; c <= hi_c; c++)
      for (int unsigned r = lo_r; r <= hi_r; r++)
        if (spin_mem[c * s + r] == centre) agree++;
    cells = (hi_c - lo_c + 1) * (hi_r - lo_r + 1);
    return agree;
  endfunction

  task automatic predict_item(input logic [1:0] op, input logic [ilac_pkg::IDX_W-1:0] idx,
                              input logic spin, input logic data);
    int unsigned s, total, col, row, cells, agree, eq, sim;
    int chg;
    lattice_result_t res;
    s     = side_in_use();
    total = s * s;
    case (op)
      ilac_pkg::OP_WRITE: begin
        if (idx < total) begin
          spin_mem[idx]  = spin;
          refpx_mem[idx] = data;
        end
      end
      ilac_pkg::OP_COUNT: begin
        eq  = 0;
        sim = 0;
        for (int unsigned c = 0; c < s; c++)
          for (int unsigned r = 0; r < s; r++) begin
            if (spin_mem[c * s + r] == refpx_mem[c * s + r]) eq++;
            sim += window_agree(s, c, r, cells) - 1;
          end
        res.kind      = ilac_pkg::KIND_COUNT;
        res.eq_count  = eq[ilac_pkg::EQ_W-1:0];
        res.sim_count = sim[ilac_pkg::SIM_W-1:0];
        res.eq_data   = 1'b0;
        res.change    = '0;
        pending_results.push_back(res);
      end
      ilac_pkg::OP_QUERY: begin
        if (idx < total) begin
          col   = idx / s;
          row   = idx - col * s;
          agree = window_agree(s, col, row, cells) - 1;
          chg   = 2 * ((int'(cells) - 1) - 2 * int'(agree));
          res.kind      = ilac_pkg::KIND_QUERY;
          res.eq_count  = '0;
          res.sim_count = '0;
          res.eq_data   = (spin_mem[idx] == refpx_mem[idx]);
          res.change    = chg[ilac_pkg::CHG_W-1:0];
          pending_results.push_back(res);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Send one transaction; valid stays high afterwards until the next call or a drain.
  task automatic send_item(input logic [1:0] op, input logic [ilac_pkg::IDX_W-1:0] idx,
                           input logic spin, input logic data);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    pixel_index_i <= idx;
    spin_value_i  <= spin;
    data_value_i  <= data;
    do @(posedge clk_i); while (in_stall_o);
    predict_item(op, idx, spin, data);
  endtask

  // Drop valid, wait for every pending result, then let the block settle.
  task automatic drain(input int unsigned settle);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Write the side register over APB, then read it back.
  task automatic write_side(input logic [ilac_pkg::SIDE_W-1:0] value);
    int got;
    drain(SETTLE_CYCLES);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SIDE_ADDR;
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    side_cfg = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = int'(prdata[ilac_pkg::SIDE_W-1:0]);
    check_field("side_length readback", int'(value), got);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Uniform lattice at full size: every site written, counts at their maximum.
  task automatic test_uniform_lattice();
    write_side(7'd64);
    no_idle = 1'b1;
    for (int unsigned i = 0; i < SITE_COUNT; i++)
      send_item(ilac_pkg::OP_WRITE, ilac_pkg::IDX_W'(i), 1'b1, 1'b1);
    no_idle = 1'b0;
    send_item(ilac_pkg::OP_COUNT, '0, 1'b0, 1'b0);
  endtask

  // Queries at corners, edges and interior, an isolated spin, the unused code and a closing count.
  task automatic test_window_edges();
    send_item(ilac_pkg::OP_QUERY, 12'd0, 1'b0, 1'b0);
    send_item(ilac_pkg::OP_QUERY, 12'd63, 1'b0, 1'b0);
    send_item(ilac_pkg::OP_QUERY, 12'd4032, 1'b0, 1'b0);
    send_item(ilac_pkg::OP_QUERY, 12'd4095, 1'b0, 1'b0);
    send_item(ilac_pkg::OP_QUERY, 12'd1, 1'b0, 1'b0);
    send_item(ilac_pkg::OP_QUERY, 12'd65, 1'b0, 1'b0);
    send_item(ilac_pkg::OP_WRITE, 12'd130, 1'b0, 1'b1);
    send_item(ilac_pkg::OP_QUERY, 12'd130, 1'b0, 1'b0);
    send_item(OP_UNUSED, 12'd130, 1'b1, 1'b1);
    send_item(ilac_pkg::OP_COUNT, 12'hfff, 1'b1, 1'b1);
  endtask

  // One-site lattice, out-of-range writes and queries, and side zero.
  task automatic test_single_site();
    write_side(7'd1);
    send_item(ilac_pkg::OP_QUERY, 12'd0, 1'b0, 1'b0);
    send_item(ilac_pkg::OP_QUERY, 12'd1, 1'b0, 1'b0);
    send_item(ilac_pkg::OP_WRITE, 12'd7, 1'b0, 1'b0);
    send_item(ilac_pkg::OP_QUERY, 12'd4095, 1'b0, 1'b0);
    send_item(ilac_pkg::OP_COUNT, 12'd0, 1'b0, 1'b0);
    send_item(OP_UNUSED, 12'd0, 1'b0, 1'b0);
    write_side(7'd0);
    send_item(ilac_pkg::OP_WRITE, 12'd0, 1'b1, 1'b0);
    send_item(ilac_pkg::OP_QUERY, 12'd0, 1'b0, 1'b0);
    send_item(ilac_pkg::OP_COUNT, 12'd0, 1'b0, 1'b0);
  endtask

  // Side above the maximum clamps to the full lattice.
  task automatic test_side_clamp();
    write_side(7'd127);
    send_item(ilac_pkg::OP_QUERY, 12'd4095, 1'b0, 1'b0);
    send_item(ilac_pkg::OP_COUNT, 12'd0, 1'b0, 1'b0);
  endtask

  // Random traffic at one side: mostly in-range writes and queries, some counts and noise.
  task automatic run_random_side(input logic [ilac_pkg::SIDE_W-1:0] side_val,
                                 input int unsigned n_items);
    int unsigned s, total, r;
    logic [1:0] op;
    logic [ilac_pkg::IDX_W-1:0] idx;
    write_side(side_val);
    s     = side_in_use();
    total = s * s;
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 50) op = ilac_pkg::OP_WRITE;
      else if (r < 60) op = ilac_pkg::OP_COUNT;
      else if (r < 95) op = ilac_pkg::OP_QUERY;
      else op = OP_UNUSED;
      if (total < SITE_COUNT && $urandom_range(0, 19) == 0)
        idx = ilac_pkg::IDX_W'($urandom_range(total, SITE_COUNT - 1));
      else
        idx = ilac_pkg::IDX_W'($urandom_range(0, total - 1));
      send_item(op, idx, 1'($urandom), 1'($urandom));
      // hold the sender now and then until the output side catches up
      if ($urandom_range(0, 49) == 0) drain(0);
    end
  endtask

  task automatic test_random_sides();
    logic [ilac_pkg::SIDE_W-1:0] sides[10] = '{7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd8,
                                               7'd11, 7'd16, 7'd2};
    for (int i = 0; i < 10; i++) begin
      no_idle = (i % 3 == 1);
      run_random_side(sides[i], 200);
    end
    no_idle = 1'b0;
  endtask

  // output side stall pattern
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left <= idle_len();
    end
  end

  always @(posedge clk_i) begin : check_results
    lattice_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, kind %0d", $time, result_kind_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", int'(want.kind), int'(result_kind_o));
        check_field("count_equal_data", int'(want.eq_count), int'(count_equal_data_o));
        check_field("count_similar", int'(want.sim_count), int'(count_similar_o));
        check_field("equal_to_data", int'(want.eq_data), int'(equal_to_data_o));
        check_field("similarity_change", int'(want.change), int'(similarity_change_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    test_uniform_lattice();
    test_window_edges();
    test_single_site();
    test_side_clamp();
    test_random_sides();
    drain(END_CYCLES);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
